[src/csss_pkg.sv]
`default_nettype none

package csss_pkg;

    localparam int TIME_W     = 48;
    localparam int DUR_W      = 48;
    localparam int VAL_W      = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [TIME_W-1:0]       run_time;
        logic [DUR_W-1:0]        run_duration;
        logic signed [VAL_W-1:0] run_value;
        logic                    run_empty;
        logic                    end_of_signal;
    } run_t;

endpackage

`default_nettype wire

[src/csss_if.sv]
`default_nettype none

interface csss_seg_if;
    logic                                 valid;
    logic                                 ready;
    logic [csss_pkg::TIME_W-1:0]          seg_time;
    logic [csss_pkg::DUR_W-1:0]           seg_duration;
    logic signed [csss_pkg::VAL_W-1:0]    seg_value;
    logic                                 final_segment;

    modport source (output valid, seg_time, seg_duration, seg_value, final_segment,
                    input ready);
    modport sink (input valid, seg_time, seg_duration, seg_value, final_segment,
                  output ready);
endinterface

interface csss_run_if;
    logic                                 valid;
    logic                                 ready;
    logic [csss_pkg::TIME_W-1:0]          run_time;
    logic [csss_pkg::DUR_W-1:0]           run_duration;
    logic signed [csss_pkg::VAL_W-1:0]    run_value;
    logic                                 run_empty;
    logic                                 end_of_signal;

    modport source (output valid, run_time, run_duration, run_value, run_empty,
                    end_of_signal, input ready);
    modport sink (input valid, run_time, run_duration, run_value, run_empty,
                  end_of_signal, output ready);
endinterface

interface csss_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [csss_pkg::DUR_W-1:0]      data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[src/compress_step_signal_segments_top.sv]
// Run-length merge of a piecewise-constant signal.
// Segments arrive on the seg channel (start time, duration, level and a
// final flag) and merged runs leave on the run channel. The minimum
// duration register is written through the cfg channel, which is always
// ready; it should be written only while no segment is in flight.
// An accepted segment is held in an input register and processed from
// there against the open run: one level compare, compares of its duration
// against zero and the minimum, and one saturating 48-bit add. Its results
// enter a four-entry result queue, from which the run channel is driven.
// One segment is taken every cycle while the queue has two entries free.
// A final segment that closes one run and flushes another yields two
// results, written to the queue together and leaving in order.
// When the receiver stalls, the queue fills and seg.ready falls once fewer
// than two entries are free; no result is lost or repeated.
// Reset empties the queue and the input register, closes the open run and
// sets the minimum duration to zero.
`default_nettype none

module compress_step_signal_segments_top (
    input  wire logic      clk,
    input  wire logic      rst_n,
    csss_seg_if.sink       seg,
    csss_run_if.source     run,
    csss_cfg_if.sink       cfg
);

    logic [csss_pkg::DUR_W-1:0]         min_dur_reg;

    logic                               s_vld_reg;
    logic [csss_pkg::TIME_W-1:0]        s_time_reg;
    logic [csss_pkg::DUR_W-1:0]         s_dur_reg;
    logic signed [csss_pkg::VAL_W-1:0]  s_val_reg;
    logic                               s_last_reg;

    logic                               open_valid_reg, open_valid_next;
    logic [csss_pkg::TIME_W-1:0]        open_time_reg, open_time_next;
    logic [csss_pkg::DUR_W-1:0]         open_dur_reg, open_dur_next;
    logic signed [csss_pkg::VAL_W-1:0]  open_level_reg, open_level_next;

    csss_pkg::run_t                     fifo_reg [csss_pkg::FIFO_DEPTH];
    logic [csss_pkg::PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [csss_pkg::PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [csss_pkg::CNT_W-1:0]         cnt_reg, cnt_next;

    logic                               fire;
    logic                               fold;
    logic                               emit_prev;
    logic                               push_a;
    logic                               push_b;
    logic                               pop;
    logic [csss_pkg::DUR_W:0]           sum;
    logic [csss_pkg::DUR_W-1:0]         sat_sum;
    csss_pkg::run_t                     res_prev;
    csss_pkg::run_t                     res_final;
    csss_pkg::run_t                     res_a;
    csss_pkg::run_t                     head;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dur_reg <= '0;
        end
        else if (cfg.valid)
        begin
            min_dur_reg <= cfg.data;
        end
    end

    assign fire      = s_vld_reg && (cnt_reg <= csss_pkg::CNT_W'(csss_pkg::FIFO_DEPTH - 2));
    assign seg.ready = !s_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg <= 1'b0;
        end
        else if (seg.ready)
        begin
            s_vld_reg <= seg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg.valid && seg.ready)
        begin
            s_time_reg <= seg.seg_time;
            s_dur_reg  <= seg.seg_duration;
            s_val_reg  <= seg.seg_value;
            s_last_reg <= seg.final_segment;
        end
    end

    assign fold = open_valid_reg && ((s_val_reg == open_level_reg) || (s_dur_reg == '0)
                  || (s_dur_reg < min_dur_reg));
    assign emit_prev = !fold && (s_dur_reg != '0) && open_valid_reg;
    assign sum       = {1'b0, open_dur_reg} + {1'b0, s_dur_reg};
    assign sat_sum   = sum[csss_pkg::DUR_W] ? '1 : sum[csss_pkg::DUR_W-1:0];

    always_comb
    begin
        open_valid_next = open_valid_reg;
        open_time_next  = open_time_reg;
        open_dur_next   = open_dur_reg;
        open_level_next = open_level_reg;

        res_prev.run_time      = open_time_reg;
        res_prev.run_duration  = open_dur_reg;
        res_prev.run_value     = open_level_reg;
        res_prev.run_empty     = 1'b0;
        res_prev.end_of_signal = 1'b0;

        if (fold)
        begin
            open_dur_next = sat_sum;
        end
        else if (s_dur_reg != '0)
        begin
            open_valid_next = 1'b1;
            open_time_next  = s_time_reg;
            open_dur_next   = s_dur_reg;
            open_level_next = s_val_reg;
        end

        if (open_valid_next)
        begin
            res_final.run_time      = open_time_next;
            res_final.run_duration  = open_dur_next;
            res_final.run_value     = open_level_next;
            res_final.run_empty     = 1'b0;
        end
        else
        begin
            res_final.run_time      = '0;
            res_final.run_duration  = '0;
            res_final.run_value     = '0;
            res_final.run_empty     = 1'b1;
        end
        res_final.end_of_signal = 1'b1;

        if (s_last_reg)
        begin
            open_valid_next = 1'b0;
            open_time_next  = '0;
            open_dur_next   = '0;
            open_level_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_valid_reg <= 1'b0;
            open_time_reg  <= '0;
            open_dur_reg   <= '0;
            open_level_reg <= '0;
        end
        else if (fire)
        begin
            open_valid_reg <= open_valid_next;
            open_time_reg  <= open_time_next;
            open_dur_reg   <= open_dur_next;
            open_level_reg <= open_level_next;
        end
    end

    assign push_a = fire && (emit_prev || s_last_reg);
    assign push_b = fire && emit_prev && s_last_reg;
    assign res_a  = emit_prev ? res_prev : res_final;
    assign pop    = run.valid && run.ready;

    assign wr_ptr_next = wr_ptr_reg + csss_pkg::PTR_W'(push_a) + csss_pkg::PTR_W'(push_b);
    assign rd_ptr_next = rd_ptr_reg + csss_pkg::PTR_W'(pop);
    assign cnt_next    = cnt_reg + csss_pkg::CNT_W'(push_a) + csss_pkg::CNT_W'(push_b)
                         - csss_pkg::CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            fifo_reg[wr_ptr_reg] <= res_a;
        end
        if (push_b)
        begin
            fifo_reg[wr_ptr_reg + csss_pkg::PTR_W'(1)] <= res_final;
        end
    end

    assign head              = fifo_reg[rd_ptr_reg];
    assign run.valid         = (cnt_reg != '0);
    assign run.run_time      = head.run_time;
    assign run.run_duration  = head.run_duration;
    assign run.run_value     = head.run_value;
    assign run.run_empty     = head.run_empty;
    assign run.end_of_signal = head.end_of_signal;

endmodule

`default_nettype wire
